>>> src/bmd_pkg.sv
// ----------------------------------------------------------------------------
// bmd_pkg
// Shared types and constants for the box overlap / min distance block.
// ----------------------------------------------------------------------------
package bmd_pkg;

    // coordinate and result widths
    localparam int DIM_W   = 24;
    localparam int SQ_W    = 2 * DIM_W;
    localparam int DSQ_W   = 52;
    localparam int DIST_W  = 26;

    // longest run before the distance sum clamps
    localparam int MAX_DIMS = 16;

    localparam logic [DIM_W-1:0] GAP_MAX = {DIM_W{1'b1}};
    localparam logic [DSQ_W-1:0] SUM_CAP =
        DSQ_W'(MAX_DIMS) * DSQ_W'(GAP_MAX) * DSQ_W'(GAP_MAX);

    // square root: first trial bit is the highest even power below 2^DSQ_W
    localparam logic [DSQ_W-1:0] ROOT_TOP_BIT = {2'b01, {(DSQ_W-2){1'b0}}};

    // queue between the accumulator and the square root unit
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    // one finished box pair, waiting for its square root
    typedef struct packed {
        logic             intersects;
        logic             contains;
        logic [DSQ_W-1:0] dist_squared;
    } t_box_sum;

    // queue status seen by the producer and the consumer
    typedef struct packed {
        logic full;
        logic valid;
    } t_q_status;

endpackage

>>> src/bmd_in_if.sv
// ----------------------------------------------------------------------------
// bmd_in_if
// Input channel: one dimension of a node box and a query box per word.
// ----------------------------------------------------------------------------
interface bmd_in_if;
    logic                            valid;
    logic                            ready;
    logic signed [bmd_pkg::DIM_W-1:0] node_low;
    logic signed [bmd_pkg::DIM_W-1:0] node_high;
    logic signed [bmd_pkg::DIM_W-1:0] query_low;
    logic signed [bmd_pkg::DIM_W-1:0] query_high;
    logic                            last_dim;

    modport source (
        output valid, node_low, node_high, query_low, query_high, last_dim,
        input  ready
    );
    modport sink (
        input  valid, node_low, node_high, query_low, query_high, last_dim,
        output ready
    );
endinterface

>>> src/bmd_out_if.sv
// ----------------------------------------------------------------------------
// bmd_out_if
// Output channel: overlap flags, squared distance and distance per box pair.
// ----------------------------------------------------------------------------
interface bmd_out_if;
    logic                         valid;
    logic                         ready;
    logic                         intersects;
    logic                         contains;
    logic [bmd_pkg::DSQ_W-1:0]    dist_squared;
    logic [bmd_pkg::DIST_W-1:0]   distance;

    modport source (
        output valid, intersects, contains, dist_squared, distance,
        input  ready
    );
    modport sink (
        input  valid, intersects, contains, dist_squared, distance,
        output ready
    );
endinterface

>>> src/box_overlap_and_min_distance.sv
// ----------------------------------------------------------------------------
// box_overlap_and_min_distance
// Streams node/query box pairs one dimension per word and returns overlap,
// containment, squared gap distance and its integer square root per pair.
// ----------------------------------------------------------------------------
//   channel  dir  handshake    word
//   i_box    in   valid/ready  node_low, node_high, query_low, query_high,
//                              last_dim
//   o_res    out  valid/ready  intersects, contains, dist_squared, distance
//
// One dimension word is taken per cycle while i_box.ready is high; a pair's
// summary passes stage A and stage B before it is pushed into the queue.
// The square root unit handles one pair at a time (load, 26 root steps,
// output); it sets the sustained rate for short boxes.
// A four-entry queue holds finished pairs; i_box.ready drops only while the
// queue is full and a pair is completing.
// Reset is synchronous, active low; there is no clearing pass.
// ----------------------------------------------------------------------------
module box_overlap_and_min_distance (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bmd_in_if.sink       i_box,
    bmd_out_if.source    o_res
);

    logic                 push, pop;
    bmd_pkg::t_box_sum    push_data, head;
    bmd_pkg::t_q_status   q_stat;

    bmd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_box       (i_box),
        .i_q_stat    (q_stat),
        .o_push      (push),
        .o_push_data (push_data)
    );

    bmd_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_stat      (q_stat),
        .o_head      (head)
    );

    bmd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (q_stat),
        .i_head   (head),
        .o_pop    (pop),
        .o_res    (o_res)
    );

endmodule

>>> src/bmd_front.sv
// ----------------------------------------------------------------------------
// bmd_front
// Per-dimension compare, gap square and saturating accumulation; pushes one
// summary per box pair into the queue.
// ----------------------------------------------------------------------------
module bmd_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bmd_in_if.sink                i_box,
    input  bmd_pkg::t_q_status    i_q_stat,
    output logic                  o_push,
    output bmd_pkg::t_box_sum     o_push_data
);

    localparam int DIFF_W = bmd_pkg::DIM_W + 1;

    logic                         en;

    // stage A: compares and gap
    logic                         r_a_v, r_a_last, r_a_ovl, r_a_enc;
    logic [bmd_pkg::DIM_W-1:0]    r_a_gap;
    // stage B: squared gap
    logic                         r_b_v, r_b_last, r_b_ovl, r_b_enc;
    logic [bmd_pkg::SQ_W-1:0]     r_b_sq;
    // running state of the current box pair
    logic                         r_ovl, r_enc;
    logic [bmd_pkg::DSQ_W-1:0]    r_sum;

    logic                         n_a_ovl, n_a_enc;
    logic [bmd_pkg::DIM_W-1:0]    n_a_gap;
    logic signed [DIFF_W-1:0]     d_lo, d_hi;
    logic [bmd_pkg::DSQ_W:0]      sum_wide;
    logic [bmd_pkg::DSQ_W-1:0]    n_sum;
    logic                         n_ovl, n_enc;

    // stall only when a finished pair cannot enter the queue
    assign en          = !(r_b_v && r_b_last && i_q_stat.full);
    assign i_box.ready = en;

    // per-dimension tests
    always_comb begin
        n_a_ovl = (i_box.node_low <= i_box.query_high) &&
                  (i_box.node_high >= i_box.query_low);
        n_a_enc = (i_box.node_low <= i_box.query_low) &&
                  (i_box.node_high >= i_box.query_high);
        d_lo    = DIFF_W'(i_box.query_low) - DIFF_W'(i_box.node_high);
        d_hi    = DIFF_W'(i_box.node_low) - DIFF_W'(i_box.query_high);
        if (i_box.node_high < i_box.query_low) begin
            n_a_gap = d_lo[bmd_pkg::DIM_W-1:0];
        end else if (i_box.query_high < i_box.node_low) begin
            n_a_gap = d_hi[bmd_pkg::DIM_W-1:0];
        end else begin
            n_a_gap = '0;
        end
    end

    // saturating accumulate and flag merge
    always_comb begin
        sum_wide = {1'b0, r_sum} + (bmd_pkg::DSQ_W + 1)'(r_b_sq);
        if (sum_wide > (bmd_pkg::DSQ_W + 1)'(bmd_pkg::SUM_CAP)) begin
            n_sum = bmd_pkg::SUM_CAP;
        end else begin
            n_sum = sum_wide[bmd_pkg::DSQ_W-1:0];
        end
        n_ovl = r_ovl & r_b_ovl;
        n_enc = r_enc & r_b_enc;
    end

    assign o_push                   = en && r_b_v && r_b_last;
    assign o_push_data.intersects   = n_ovl;
    assign o_push_data.contains     = n_enc;
    assign o_push_data.dist_squared = n_sum;

    // pipeline valids and running state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_ovl <= 1'b1;
            r_enc <= 1'b1;
            r_sum <= '0;
        end else if (en) begin
            r_a_v <= i_box.valid;
            r_b_v <= r_a_v;
            if (r_b_v) begin
                if (r_b_last) begin
                    r_ovl <= 1'b1;
                    r_enc <= 1'b1;
                    r_sum <= '0;
                end else begin
                    r_ovl <= n_ovl;
                    r_enc <= n_enc;
                    r_sum <= n_sum;
                end
            end
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_last <= i_box.last_dim;
            r_a_ovl  <= n_a_ovl;
            r_a_enc  <= n_a_enc;
            r_a_gap  <= n_a_gap;
            r_b_last <= r_a_last;
            r_b_ovl  <= r_a_ovl;
            r_b_enc  <= r_a_enc;
            r_b_sq   <= r_a_gap * r_a_gap;
        end
    end

endmodule

>>> src/bmd_queue.sv
// ----------------------------------------------------------------------------
// bmd_queue
// Small FIFO of finished box pair summaries.
// ----------------------------------------------------------------------------
module bmd_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  bmd_pkg::t_box_sum     i_push_data,
    input  logic                  i_pop,
    output bmd_pkg::t_q_status    o_stat,
    output bmd_pkg::t_box_sum     o_head
);

    bmd_pkg::t_box_sum            r_mem [bmd_pkg::Q_DEPTH];
    logic [bmd_pkg::Q_PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [bmd_pkg::Q_PTR_W:0]    r_count;

    assign o_stat.full  = (r_count == (bmd_pkg::Q_PTR_W + 1)'(bmd_pkg::Q_DEPTH));
    assign o_stat.valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_push_data;
    end

endmodule

>>> src/bmd_back.sv
// ----------------------------------------------------------------------------
// bmd_back
// Bit-serial integer square root (two input bits per cycle) and the
// output register.
// ----------------------------------------------------------------------------
module bmd_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  bmd_pkg::t_q_status    i_q_stat,
    input  bmd_pkg::t_box_sum     i_head,
    output logic                  o_pop,
    bmd_out_if.source             o_res
);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state                       r_state;
    logic [bmd_pkg::DSQ_W-1:0]    r_rem, r_root, r_bit;
    bmd_pkg::t_box_sum            r_job;
    logic                         r_o_valid;
    logic                         r_o_int, r_o_cont;
    logic [bmd_pkg::DSQ_W-1:0]    r_o_dsq;
    logic [bmd_pkg::DIST_W-1:0]   r_o_dist;

    logic [bmd_pkg::DSQ_W:0]      trial;
    logic                         fits;
    logic                         slot_free;

    // one restoring step of the root recurrence
    assign trial     = {1'b0, r_root} + {1'b0, r_bit};
    assign fits      = {1'b0, r_rem} >= trial;
    assign slot_free = !r_o_valid || o_res.ready;
    assign o_pop     = (r_state == S_IDLE) && i_q_stat.valid;

    assign o_res.valid        = r_o_valid;
    assign o_res.intersects   = r_o_int;
    assign o_res.contains     = r_o_cont;
    assign o_res.dist_squared = r_o_dsq;
    assign o_res.distance     = r_o_dist;

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            if (r_o_valid && o_res.ready) r_o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_stat.valid) begin
                        r_job   <= i_head;
                        r_rem   <= i_head.dist_squared;
                        r_root  <= '0;
                        r_bit   <= bmd_pkg::ROOT_TOP_BIT;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (r_bit != '0) begin
                        if (fits) begin
                            r_rem  <= r_rem - trial[bmd_pkg::DSQ_W-1:0];
                            r_root <= (r_root >> 1) + r_bit;
                        end else begin
                            r_root <= r_root >> 1;
                        end
                        r_bit <= r_bit >> 2;
                    end else if (slot_free) begin
                        r_o_valid <= 1'b1;
                        r_o_int   <= r_job.intersects;
                        r_o_cont  <= r_job.contains;
                        r_o_dsq   <= r_job.dist_squared;
                        r_o_dist  <= r_root[bmd_pkg::DIST_W-1:0];
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> src/bmd_checker.sv
// ----------------------------------------------------------------------------
// bmd_checker
// Port-level checks on the result channel of the top level.
// ----------------------------------------------------------------------------
module bmd_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic                        i_out_intersects,
    input  logic [bmd_pkg::DSQ_W-1:0]   i_out_dsq,
    input  logic [bmd_pkg::DIST_W-1:0]  i_out_dist
);

    localparam int W = bmd_pkg::DSQ_W + 2;

    logic [W-1:0] root_sq, next_sq;

    assign root_sq = W'(i_out_dist) * W'(i_out_dist);
    assign next_sq = (W'(i_out_dist) + W'(1)) * (W'(i_out_dist) + W'(1));

    // no result right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // distance is the floored root of the squared distance
    a_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (root_sq <= W'(i_out_dsq)) && (next_sq > W'(i_out_dsq)))
        else $error("distance is not the floored square root");

    // overlapping boxes are at distance zero
    a_overlap_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_intersects |-> i_out_dsq == '0)
        else $error("intersecting pair with nonzero distance");

    // clamped sum never exceeds its cap
    a_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_dsq <= bmd_pkg::SUM_CAP)
        else $error("squared distance above saturation cap");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_dsq) && $stable(i_out_dist))
        else $error("stalled result changed");

endmodule

bind box_overlap_and_min_distance bmd_checker u_bmd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_res.valid),
    .i_out_ready      (o_res.ready),
    .i_out_intersects (o_res.intersects),
    .i_out_dsq        (o_res.dist_squared),
    .i_out_dist       (o_res.distance)
);
